### sv/phtc_pkg.sv
// Types, codes and constants shared by the parallel handshake transfer controller.
package phtc_pkg;

  localparam int unsigned BUF_AW = 12;
  localparam logic [12:0] BUF_DEPTH = 13'(1 << BUF_AW);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STROBE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] KIND_RX_PART = 3'd0;
  localparam logic [2:0] KIND_RX_FULL = 3'd1;
  localparam logic [2:0] KIND_TX_PART = 3'd2;
  localparam logic [2:0] KIND_TX_FULL = 3'd3;
  localparam logic [2:0] KIND_NONE    = 3'd4;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_RUNNING = 2'd2;

  localparam logic [2:0] RES_PULSE = 3'd0;
  localparam logic [2:0] RES_RECV  = 3'd1;
  localparam logic [2:0] RES_DRIVE = 3'd2;
  localparam logic [2:0] RES_ID    = 3'd3;
  localparam logic [2:0] RES_DONE  = 3'd4;
  localparam logic [2:0] RES_FAIL  = 3'd5;
  localparam logic [2:0] RES_DISC  = 3'd6;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_HOLDOFF = 2'd1;
  localparam logic [1:0] CFG_NOISE   = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [9:0]  HOLDOFF_RST = 10'd500;
  localparam logic [3:0]  NOISE_RST   = 4'd8;
  localparam logic [3:0]  NOISE_MAX   = 4'd15;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic        id_known;
    logic        direction_line;
    logic [7:0]  port_byte;
    logic [7:0]  load_value;
    logic [11:0] load_index;
    logic [12:0] transfer_length;
    logic [1:0]  transfer_kind;
    logic [1:0]  opcode;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  result_byte;
    logic [12:0] byte_count;
    logic        port_drives;
  } res_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] data, logic [12:0] count,
                                  logic drives);
    res_t r;
    r.result_kind = kind;
    r.result_byte = data;
    r.byte_count  = count;
    r.port_drives = drives;
    return r;
  endfunction

endpackage

### sv/parallel_handshake_transfer_ctrl.sv
// Top level of the parallel handshake transfer controller.
// An accepted beat is held in the input register until the result register is free,
// is then processed, and its results are registered before they are offered.
// Throughput: one input beat per cycle while the result port is free; an item with
// several results holds that port until all are taken, so the result register sets the rate.
// Reset clears all control state; the 4096-byte send buffer is not cleared.
module parallel_handshake_transfer_ctrl
  import phtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // transfer_kind, transfer_length, load_index, load_value, port_byte,
  // direction_line, id_known, then zero fill.
  input  logic [47:0] s_axis_tdata,
  // opcode.
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_byte, byte_count, port_drives, then zero fill.
  output logic [23:0] m_axis_tdata,
  // result_kind.
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] timeout_q;
  logic [9:0]  holdoff_q;
  logic [3:0]  limit_q;

  logic        in_vld_q;
  item_t       in_q;

  logic [2:0]  cur_q, cur_d, prev_q, prev_d;
  logic [1:0]  phase_q, phase_d;
  logic [12:0] pos_q, pos_d, len_q, len_d;
  logic [3:0]  noise_q, noise_d;
  logic [15:0] idle_q, idle_d;
  logic        armed_q, armed_d;
  logic [9:0]  hold_q, hold_d;
  logic        port_q, port_d;

  res_t        res_q [MAX_RES];
  res_t        res_d [MAX_RES];
  logic [2:0]  res_left_q;
  logic [1:0]  res_idx_q;
  logic [2:0]  res_n;

  logic [7:0]  mem [int'(BUF_DEPTH)];
  logic [7:0]  rd_q, byp_data_q;
  logic        byp_q;
  logic        mem_we;
  logic [11:0] mem_raddr;
  logic [7:0]  rd_byte;

  logic        fire, res_free;
  logic [12:0] len_sat, pos_n;
  logic [3:0]  nc;
  logic        init_send, do_noise, do_drive, do_recv, do_adv;
  res_t        res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      holdoff_q <= HOLDOFF_RST;
      limit_q   <= NOISE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_HOLDOFF: holdoff_q <= cfg_data_i[9:0];
        CFG_NOISE:   limit_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign res_free      = (res_left_q == 3'd0) || ((res_left_q == 3'd1) && m_axis_tready);
  assign fire          = in_vld_q && res_free;
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= item_t'({s_axis_tdata[44:0], s_axis_tuser});
    end
  end

  assign rd_byte = (pos_q >= BUF_DEPTH) ? 8'd0 : (byp_q ? byp_data_q : rd_q);

  always_comb begin
    cur_d     = cur_q;
    prev_d    = prev_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    noise_d   = noise_q;
    idle_d    = idle_q;
    armed_d   = armed_q;
    hold_d    = hold_q;
    port_d    = port_q;
    res_d     = res_q;
    res_n     = 3'd0;
    mem_we    = 1'b0;
    len_sat   = (in_q.transfer_length > BUF_DEPTH) ? BUF_DEPTH : in_q.transfer_length;
    init_send = 1'b0;
    do_noise  = 1'b0;
    do_drive  = 1'b0;
    do_recv   = 1'b0;
    do_adv    = 1'b0;
    pos_n     = pos_q + 13'd1;
    nc        = (noise_q != NOISE_MAX) ? noise_q + 4'd1 : noise_q;

    if (fire) begin
      case (in_q.opcode)
        OP_START: begin
          cur_d     = {1'b0, in_q.transfer_kind};
          len_d     = len_sat;
          pos_d     = '0;
          init_send = in_q.transfer_kind[1] && (prev_q != KIND_TX_PART);
          phase_d   = init_send ? PH_PENDING : PH_RUNNING;
          armed_d   = 1'b1;
          idle_d    = '0;
          if (init_send) begin
            res_d[res_n[1:0]] = mk_res(RES_PULSE, 8'd0, 13'd0, port_d);
            res_n = res_n + 3'd1;
          end
          if (({1'b0, in_q.transfer_kind} == KIND_RX_PART) || (prev_q == KIND_RX_PART) ||
              (prev_q == KIND_TX_PART)) begin
            res_d[res_n[1:0]] = mk_res(RES_PULSE, 8'd0, 13'd0, port_d);
            res_n = res_n + 3'd1;
          end
        end
        OP_LOAD: begin
          mem_we = 1'b1;
        end
        OP_STROBE: begin
          if (hold_q == 10'd0) begin
            idle_d = '0;
            if (phase_q == PH_PENDING) begin
              if (in_q.direction_line) begin
                do_noise = 1'b1;
              end else begin
                noise_d  = '0;
                port_d   = 1'b1;
                phase_d  = PH_RUNNING;
                do_drive = 1'b1;
              end
            end else if (cur_q == KIND_NONE) begin
              if (!in_q.direction_line || !in_q.id_known) begin
                do_noise = 1'b1;
              end else begin
                noise_d = '0;
                res_d[res_n[1:0]] = mk_res(RES_ID, in_q.port_byte, 13'd0, port_d);
                res_n = res_n + 3'd1;
              end
            end else if ((cur_q == KIND_RX_PART) || (cur_q == KIND_RX_FULL)) begin
              do_recv = 1'b1;
            end else begin
              do_drive = 1'b1;
            end

            if (do_recv) begin
              res_d[res_n[1:0]] = mk_res(RES_RECV, in_q.port_byte, pos_q, port_d);
              res_n  = res_n + 3'd1;
              do_adv = 1'b1;
            end
            if (do_drive) begin
              res_d[res_n[1:0]] = mk_res(RES_DRIVE, rd_byte, pos_q, port_d);
              res_n  = res_n + 3'd1;
              do_adv = 1'b1;
            end
            if (do_adv) begin
              pos_d = pos_n;
              if (pos_n < len_q) begin
                res_d[res_n[1:0]] = mk_res(RES_PULSE, 8'd0, pos_n, port_d);
                res_n = res_n + 3'd1;
              end else begin
                prev_d  = cur_q;
                cur_d   = KIND_NONE;
                phase_d = PH_IDLE;
                armed_d = 1'b0;
                if ((cur_q == KIND_TX_FULL) || (cur_q == KIND_RX_FULL)) begin
                  res_d[res_n[1:0]] = mk_res(RES_PULSE, 8'd0, pos_n, port_d);
                  res_n = res_n + 3'd1;
                end
                if (cur_q != KIND_TX_PART) begin
                  port_d = 1'b0;
                end
                res_d[res_n[1:0]] = mk_res(RES_DONE, 8'd0, len_q, port_d);
                res_n = res_n + 3'd1;
              end
            end
            if (do_noise) begin
              if (nc >= limit_q) begin
                if (cur_q != KIND_NONE) begin
                  port_d  = 1'b0;
                  cur_d   = KIND_NONE;
                  prev_d  = KIND_NONE;
                  phase_d = PH_IDLE;
                  armed_d = 1'b0;
                  res_d[res_n[1:0]] = mk_res(RES_FAIL, 8'd0,
                                             (pos_q != 13'd0) ? pos_q - 13'd1 : 13'd0, port_d);
                  res_n = res_n + 3'd1;
                end
                port_d = 1'b0;
                hold_d = holdoff_q;
                res_d[res_n[1:0]] = mk_res(RES_DISC, 8'd0, 13'd0, port_d);
                res_n   = res_n + 3'd1;
                noise_d = '0;
              end else begin
                noise_d = nc;
              end
            end
          end
        end
        default: begin
          if (hold_q != 10'd0) begin
            hold_d = hold_q - 10'd1;
          end
          if (armed_q) begin
            if (idle_q >= timeout_q) begin
              port_d  = 1'b0;
              cur_d   = KIND_NONE;
              prev_d  = KIND_NONE;
              phase_d = PH_IDLE;
              armed_d = 1'b0;
              res_d[res_n[1:0]] = mk_res(RES_FAIL, 8'd0,
                                         (pos_q != 13'd0) ? pos_q - 13'd1 : 13'd0, port_d);
              res_n = res_n + 3'd1;
            end else begin
              idle_d = idle_q + 16'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= KIND_NONE;
      prev_q  <= KIND_NONE;
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      noise_q <= '0;
      idle_q  <= '0;
      armed_q <= 1'b0;
      hold_q  <= '0;
      port_q  <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      noise_q <= noise_d;
      idle_q  <= idle_d;
      armed_q <= armed_d;
      hold_q  <= hold_d;
      port_q  <= port_d;
    end
  end

  // The buffer is read every cycle at the next position, so the byte for the
  // current position is ready when a strobe is processed.
  assign mem_raddr = pos_d[BUF_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_q.load_index] <= in_q.load_value;
    end
    rd_q       <= mem[mem_raddr];
    byp_q      <= mem_we && (in_q.load_index == mem_raddr);
    byp_data_q <= in_q.load_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_left_q <= '0;
      res_idx_q  <= '0;
    end else if (fire) begin
      res_left_q <= res_n;
      res_idx_q  <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      res_left_q <= res_left_q - 3'd1;
      res_idx_q  <= res_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_out       = res_q[res_idx_q];
  assign m_axis_tvalid = (res_left_q != 3'd0);
  assign m_axis_tlast  = (res_left_q == 3'd1);
  assign m_axis_tuser  = res_out.result_kind;
  assign m_axis_tdata  = {2'b00, res_out.port_drives, res_out.byte_count, res_out.result_byte};

`ifndef SYNTHESIS
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_left_q <= 3'd4) else $error("result count out of range");

  a_idle_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) == (cur_q == KIND_NONE)) else $error("phase and kind disagree");

  a_pending_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PENDING) |-> ((cur_q == KIND_TX_PART) || (cur_q == KIND_TX_FULL)))
    else $error("pending without a send transfer");

  a_armed_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (phase_q != PH_IDLE)) else $error("timeout armed while idle");

  a_silent_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res_n == 3'd0)) |=> !m_axis_tvalid) else $error("result from silent item");
`endif

endmodule
